>>> design/swed_pkg.sv
// Shared constants, types and register codes of the sliding-window encounter detector.
// No dependencies; every other design file imports this package.

package swed_pkg;

	// Sizing of the window, the block index and the click count
	localparam int MAX_WINDOW = 64;
	localparam int INDEX_BITS = 24;
	localparam int COUNT_BITS = 16;

	// Register widths and the configuration port
	localparam int CLICKS_W   = 16;
	localparam int WINREG_W   = 7;
	localparam int HITS_W     = 7;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_CLICKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HITS   = 2'd2;

	// Window storage: current block plus MAX_WINDOW older blocks
	localparam int WIN_LEN  = MAX_WINDOW + 1;
	localparam int WIN_BITS = $clog2(MAX_WINDOW + 1);
	localparam int AGE_BITS = $clog2(MAX_WINDOW + 2);
	localparam logic [AGE_BITS-1:0] AGE_NONE = '1;

	// Window scans walk eight positions per cycle
	localparam int LANES       = 8;
	localparam int LANE_BITS   = $clog2(LANES);
	localparam int SCAN_GROUPS = (WIN_LEN + LANES - 1) / LANES;
	localparam int RC_GROUPS   = (MAX_WINDOW + LANES - 1) / LANES;
	localparam int GRP_BITS    = $clog2(SCAN_GROUPS + 1);
	localparam int POS_BITS    = GRP_BITS + LANE_BITS;
	localparam int PAD_LEN     = (1 << GRP_BITS) * LANES;

	// Common width for the hit threshold compare
	localparam int CMP_W = (COUNT_BITS > CLICKS_W) ? COUNT_BITS : CLICKS_W;

	// Register values seen by the back end
	typedef struct packed {
		logic [CLICKS_W-1:0] clicks;
		logic [WIN_BITS-1:0] window;     // clamped to 1..MAX_WINDOW
		logic [HITS_W-1:0]   hits;
		logic                window_wr;  // window length written this cycle
	} cfg_t;

	// One queued block after classification
	typedef struct packed {
		logic hit;
		logic last;
	} qent_t;

	// Queue head offered to the back end
	typedef struct packed {
		logic valid;
		logic hit;
		logic last;
	} qhead_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_RECOUNT,
		B_SCAN,
		B_DRAIN
	} bstate_t;

endpackage

>>> design/swed_if.sv
// Valid/ready channel interfaces for block items and encounter results.
// Depends on swed_pkg for the field widths.

interface swed_in_if import swed_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [COUNT_BITS-1:0] click_count;
	logic                  last_block;

	modport source (output valid, output click_count, output last_block, input ready);
	modport sink   (input valid, input click_count, input last_block, output ready);
endinterface

interface swed_out_if import swed_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [INDEX_BITS-1:0] enc_start;
	logic [INDEX_BITS-1:0] enc_end;
	logic                  at_stream_end;

	modport source (output valid, output enc_start, output enc_end, output at_stream_end,
		input ready);
	modport sink   (input valid, input enc_start, input enc_end, input at_stream_end,
		output ready);
endinterface

>>> design/swed_front.sv
// Front end: configuration registers, hit classification and a two-entry block queue.
// Depends on swed_pkg and the swed_in_if interface.

module swed_front import swed_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	swed_in_if.sink               blocks,
	input  logic                  pop,
	output cfg_t                  cfg,
	output qhead_t                head
);

	localparam int QDEPTH = 2;
	localparam int QP_BITS = $clog2(QDEPTH);
	localparam int QC_BITS = $clog2(QDEPTH + 1);

	logic [CLICKS_W-1:0] clicks_q;
	logic [WINREG_W-1:0] window_q;
	logic [HITS_W-1:0]   hits_q;

	qent_t               slot_q [QDEPTH];
	logic [QP_BITS-1:0]  wr_ptr_q;
	logic [QP_BITS-1:0]  rd_ptr_q;
	logic [QC_BITS-1:0]  count_q;
	logic                push;
	logic                is_hit;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clicks_q <= CLICKS_W'(15);
			window_q <= WINREG_W'(10);
			hits_q   <= HITS_W'(5);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CLICKS: clicks_q <= cfg_wdata[CLICKS_W-1:0];
				REG_WINDOW: window_q <= cfg_wdata[WINREG_W-1:0];
				REG_HITS:   hits_q   <= cfg_wdata[HITS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Clamp the window length into 1..MAX_WINDOW
	always_comb begin
		cfg.clicks    = clicks_q;
		cfg.hits      = hits_q;
		cfg.window_wr = cfg_we && (cfg_index == REG_WINDOW);
		if (window_q == '0) begin
			cfg.window = WIN_BITS'(1);
		end else if (window_q > WINREG_W'(MAX_WINDOW)) begin
			cfg.window = WIN_BITS'(MAX_WINDOW);
		end else begin
			cfg.window = WIN_BITS'(window_q);
		end
	end

	// Classify the incoming beat
	assign is_hit       = CMP_W'(blocks.click_count) >= CMP_W'(clicks_q);
	assign blocks.ready = count_q != QC_BITS'(QDEPTH);
	assign push         = blocks.valid && blocks.ready;

	// Queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= '{hit: is_hit, last: blocks.last_block};
		end
	end

	assign head.valid = count_q != '0;
	assign head.hit   = slot_q[rd_ptr_q].hit;
	assign head.last  = slot_q[rd_ptr_q].last;

endmodule

>>> design/swed_back.sv
// Back end: hit window, running sum, encounter tracking, oldest-hit scan, end-of-run drain
// and the result register. Depends on swed_pkg and the swed_out_if interface.

module swed_back import swed_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  qhead_t      head,
	output logic        pop,
	swed_out_if.source  encounters
);

	function automatic logic [INDEX_BITS-1:0] floor_back(input logic [INDEX_BITS-1:0] b,
		input logic [AGE_BITS-1:0] k);
		logic [INDEX_BITS-1:0] kx;
		kx = INDEX_BITS'(k);
		return (b >= kx) ? (b - kx) : '0;
	endfunction

	bstate_t               state_q, state_d;
	logic [WIN_LEN-1:0]    win_q;
	logic [PAD_LEN-1:0]    win_pad;
	logic [WIN_BITS-1:0]   sum_q;
	logic                  in_enc_q;
	logic [INDEX_BITS-1:0] index_q;
	logic [INDEX_BITS-1:0] start_q;
	logic [AGE_BITS-1:0]   age_q;     // distance of the newest hit, AGE_NONE if none
	logic                  last_q;
	logic                  pend_q;    // window sum must be recounted
	logic [GRP_BITS-1:0]   grp_q;
	logic [WIN_BITS-1:0]   rem_q;

	logic                  out_valid_q;
	logic [INDEX_BITS-1:0] out_start_q;
	logic [INDEX_BITS-1:0] out_end_q;
	logic                  out_flag_q;

	// Datapath terms
	logic                  out_free;
	logic [AGE_BITS-1:0]   w_age;
	logic [WIN_BITS-1:0]   w_m1;
	logic                  leave;
	logic [WIN_BITS-1:0]   sum_nx;
	logic                  here;
	logic [AGE_BITS-1:0]   age_k1;
	logic [AGE_BITS-1:0]   age_nx;
	logic [INDEX_BITS-1:0] close_end;
	logic [LANES-1:0]      lane;
	logic [POS_BITS-1:0]   pos_j;
	logic                  scan_found;
	logic [POS_BITS-1:0]   scan_pos;
	logic [INDEX_BITS-1:0] scan_start;
	logic [LANE_BITS:0]    rc_cnt;
	logic                  removed;
	logic [WIN_BITS-1:0]   s_new;
	logic                  drain_close;
	logic [AGE_BITS-1:0]   rem_age;
	logic [INDEX_BITS-1:0] drain_end;

	// Control terms
	logic                  upd;
	logic                  closing;
	logic                  opening;
	logic                  rc_start;
	logic                  rc_fin;
	logic                  scan_fin;
	logic                  drain_fin;
	logic                  load;
	logic [INDEX_BITS-1:0] load_end;
	logic                  clear;
	logic                  bump;

	// Shift-in update of one block
	assign out_free = !out_valid_q || encounters.ready;
	assign w_age    = AGE_BITS'(cfg.window);
	assign w_m1     = cfg.window - WIN_BITS'(1);
	assign leave    = win_q[w_m1];
	assign sum_nx   = sum_q + WIN_BITS'(head.hit) - WIN_BITS'(leave);
	assign here     = HITS_W'(sum_nx) >= cfg.hits;
	assign age_k1   = (age_q == AGE_NONE) ? AGE_NONE : (age_q + 1'b1);
	assign age_nx   = head.hit ? '0 : age_k1;
	assign close_end = (age_k1 <= w_age) ? (index_q - INDEX_BITS'(age_k1))
		: floor_back(index_q, w_age);

	// Eight-position slice of the window for the scan and the recount
	assign win_pad = PAD_LEN'(win_q);
	assign lane    = win_pad[{grp_q, {LANE_BITS{1'b0}}} +: LANES];

	always_comb begin
		scan_found = 1'b0;
		scan_pos   = '0;
		rc_cnt     = '0;
		pos_j      = '0;
		for (int j = 0; j < LANES; j++) begin
			pos_j = {grp_q, LANE_BITS'(j)};
			if (lane[j] && (pos_j <= POS_BITS'(cfg.window))) begin
				scan_found = 1'b1;
				scan_pos   = pos_j;
			end
			if (lane[j] && (pos_j < POS_BITS'(cfg.window))) begin
				rc_cnt = rc_cnt + 1'b1;
			end
		end
	end

	assign scan_start = scan_found ? (index_q - INDEX_BITS'(scan_pos))
		: floor_back(index_q, w_age);

	// One drain step: drop the oldest remaining block
	assign removed     = win_q[rem_q];
	assign s_new       = sum_q - WIN_BITS'(removed);
	assign drain_close = HITS_W'(s_new) < cfg.hits;
	assign rem_age     = AGE_BITS'(rem_q);
	assign drain_end   = (age_q <= rem_age) ? (index_q - INDEX_BITS'(age_q))
		: floor_back(index_q, rem_age);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (pend_q) begin
					state_d = B_RECOUNT;
				end else if (upd) begin
					if (opening) begin
						state_d = B_SCAN;
					end else if (head.last && here) begin
						state_d = B_DRAIN;
					end
				end
			end
			B_RECOUNT: begin
				if (rc_fin) begin
					state_d = B_IDLE;
				end
			end
			B_SCAN: begin
				if (scan_fin) begin
					state_d = last_q ? B_DRAIN : B_IDLE;
				end
			end
			B_DRAIN: begin
				if (drain_fin) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		upd       = 1'b0;
		rc_start  = 1'b0;
		rc_fin    = 1'b0;
		scan_fin  = 1'b0;
		drain_fin = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				rc_start = pend_q;
				upd      = !pend_q && head.valid && out_free;
			end
			B_RECOUNT: rc_fin = grp_q == GRP_BITS'(RC_GROUPS - 1);
			B_SCAN:    scan_fin = scan_found || (grp_q == '0);
			B_DRAIN:   drain_fin = out_free && (drain_close || (rem_q == '0));
			default: begin
			end
		endcase
		closing  = in_enc_q && !here;
		opening  = !in_enc_q && here;
		pop      = upd;
		load     = (upd && closing) || drain_fin;
		load_end = upd ? close_end : (drain_close ? drain_end : index_q);
		clear    = (upd && head.last && !here) || drain_fin;
		bump     = (upd && !head.last && !opening) || (scan_fin && !last_q);
	end

	// Window, sum and encounter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			win_q    <= '0;
			sum_q    <= '0;
			in_enc_q <= 1'b0;
			index_q  <= '0;
			start_q  <= '0;
			age_q    <= AGE_NONE;
			last_q   <= 1'b0;
			pend_q   <= 1'b0;
			grp_q    <= '0;
			rem_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cfg.window_wr) begin
				pend_q <= 1'b1;
			end else if (rc_start) begin
				pend_q <= 1'b0;
			end
			if (clear) begin
				// Return to the reset state after the last block
				win_q    <= '0;
				sum_q    <= '0;
				in_enc_q <= 1'b0;
				index_q  <= '0;
				start_q  <= '0;
				age_q    <= AGE_NONE;
			end else begin
				unique case (state_q)
					B_IDLE: begin
						if (rc_start) begin
							sum_q <= '0;
							grp_q <= '0;
						end else if (upd) begin
							win_q    <= {win_q[WIN_LEN-2:0], head.hit};
							sum_q    <= sum_nx;
							age_q    <= age_nx;
							in_enc_q <= here;
							last_q   <= head.last;
							grp_q    <= GRP_BITS'(cfg.window >> LANE_BITS);
							rem_q    <= w_m1;
						end
					end
					B_RECOUNT: begin
						sum_q <= sum_q + WIN_BITS'(rc_cnt);
						grp_q <= grp_q + 1'b1;
					end
					B_SCAN: begin
						if (scan_fin) begin
							start_q <= scan_start;
						end else begin
							grp_q <= grp_q - 1'b1;
						end
					end
					B_DRAIN: begin
						if (out_free && !drain_fin) begin
							sum_q <= s_new;
							rem_q <= rem_q - 1'b1;
						end
					end
					default: begin
					end
				endcase
				if (bump) begin
					index_q <= index_q + 1'b1;
				end
			end
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (encounters.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_start_q <= start_q;
			out_end_q   <= load_end;
			out_flag_q  <= state_q == B_DRAIN;
		end
	end

	assign encounters.valid         = out_valid_q;
	assign encounters.enc_start     = out_start_q;
	assign encounters.enc_end       = out_end_q;
	assign encounters.at_stream_end = out_flag_q;

	// A drain only runs on an open encounter
	a_drain_open: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DRAIN) |-> in_enc_q)
		else $error("drain running without an open encounter");

	// A block is taken only when a result can be stored
	a_pop_room: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> out_free)
		else $error("block taken while the result register is full");

	// Newest-hit distance agrees with the current block's flag
	a_age_bit0: assert property (@(posedge clk) disable iff (!arst_n)
		win_q[0] == (age_q == '0))
		else $error("newest-hit distance out of step with the window");

	// The running sum never exceeds the window length once settled
	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == B_IDLE) && !pend_q) |-> (sum_q <= cfg.window))
		else $error("window sum larger than the window");

endmodule

>>> design/sliding_window_encounter_detector_top.sv
// Top level of the sliding-window encounter detector: configuration port and both channels.
// Depends on swed_pkg, swed_if, swed_front and swed_back.

// Each beat on blocks carries one time block's click count; a block is a hit when the count
// reaches clicks_per_block. An encounter opens when the hits among the last window_blocks
// blocks reach hits_per_encounter and closes when they fall below; each close delivers one
// beat on encounters with the first and last hit's block index. On a beat with last_block
// set the window drains, which may close an open encounter with at_stream_end set, and the
// block index returns to zero. The front end accepts one beat per cycle into a two-entry
// queue while the queue has room. A block that opens an encounter is followed by an
// oldest-hit scan, eight window positions per cycle. A last block with an open encounter
// then drains the window, one position per step. A write to window_blocks starts a
// recount of the window sum before the next block: one clearing step, then eight steps
// of eight positions each.
// Registers must be written only while no block is in flight; the user keeps to this, unenforced by the block.

module sliding_window_encounter_detector_top import swed_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	swed_in_if.sink               blocks,
	swed_out_if.source            encounters
);

	cfg_t   cfg;
	qhead_t head;
	logic   pop;

	// Accept, classify and queue blocks
	swed_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.blocks    (blocks),
		.pop       (pop),
		.cfg       (cfg),
		.head      (head)
	);

	// Track the window and deliver encounters
	swed_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head       (head),
		.pop        (pop),
		.encounters (encounters)
	);

endmodule

>>> dv/sliding_window_encounter_detector_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for sliding_window_encounter_detector_top: directed rows, then bursty
// random block streams over varied register settings. Depends on swed_pkg and swed_if.

module sliding_window_encounter_detector_top_tb;
	import swed_pkg::*;

	localparam int RANDOM_BLOCKS = 500;
	localparam int SETTLE_CYCLES = 120;
	localparam int LONG_HOLD     = 400;
	localparam int STALL_LIMIT   = 4000;

	localparam logic [CLICKS_W-1:0] CLICKS_AT_RESET = 16'd15;
	localparam logic [WINREG_W-1:0] WINDOW_AT_RESET = 7'd10;
	localparam logic [HITS_W-1:0]   HITS_AT_RESET   = 7'd5;

	typedef struct packed {
		logic [INDEX_BITS-1:0] first_blk;
		logic [INDEX_BITS-1:0] last_blk;
		logic                  drained;
	} encounter_t;

	typedef enum logic {ROW_REG, ROW_BLOCK} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		logic [COUNT_BITS-1:0] clicks;
		logic                  is_last;
		logic                  typed;
		encounter_t            want;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	swed_in_if  blk_ch ();
	swed_out_if enc_ch ();

	sliding_window_encounter_detector_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.blocks     (blk_ch),
		.encounters (enc_ch)
	);

	// Mirror of the detector: window flags, encounter status, indexes and registers
	logic [MAX_WINDOW:0]   recent_hits;
	logic                  enc_open;
	logic [INDEX_BITS-1:0] blk_idx;
	logic [INDEX_BITS-1:0] open_first;
	logic [CLICKS_W-1:0]   thr_clicks;
	logic [WINREG_W-1:0]   win_reg;
	logic [HITS_W-1:0]     hits_reg;

	encounter_t due_encounters[$];
	encounter_t oldest_due;
	stim_row_t  directed_rows[$];
	stim_row_t  row;

	int errors;
	int quiet_cycles;
	int directed_blocks;
	int random_blocks;
	int settings_count;
	int seen_encounters;
	int drained_encounters;
	int long_holds;
	bit hold_request;
	bit tx_calm;
	bit cfg_open;
	bit burst;
	int phase;
	int run_len;
	int i;
	int rx_gap;
	int rx_span;
	bit rx_calm;
	logic [CLICKS_W-1:0] new_clicks;
	logic [WINREG_W-1:0] new_window;
	logic [HITS_W-1:0]   new_hits;
	logic [2:0]          write_mask;
	logic                end_run;

	// Clock: 2 ns period
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic int window_span();
		if (win_reg == 0)
			return 1;
		if (win_reg > MAX_WINDOW)
			return MAX_WINDOW;
		return int'(win_reg);
	endfunction

	// Hits at window positions 0..hi (empty when hi < 0)
	function automatic int hits_upto(int hi);
		int sum;
		sum = 0;
		for (int k = 0; k <= hi && k <= MAX_WINDOW; k++)
			sum += recent_hits[k];
		return sum;
	endfunction

	// Position k blocks back, held at index 0 instead of wrapping
	function automatic logic [INDEX_BITS-1:0] back_clamped(logic [INDEX_BITS-1:0] idx, int k);
		return (idx >= INDEX_BITS'(k)) ? idx - INDEX_BITS'(k) : '0;
	endfunction

	task automatic clear_tracker();
		recent_hits = '0;
		enc_open    = 1'b0;
		blk_idx     = '0;
		open_first  = '0;
	endtask

	// Advance the mirror by one block; flag a closed encounter and its fields
	task automatic track_encounters(input logic [COUNT_BITS-1:0] clicks, input logic is_last,
		output bit closed, output encounter_t enc);
		int w;
		int d;
		int k;
		bit now_in;
		bit found;
		logic [INDEX_BITS-1:0] b;
		logic [INDEX_BITS-1:0] pos;
		w = window_span();
		b = blk_idx;
		closed = 1'b0;
		enc = '0;
		recent_hits = {recent_hits[MAX_WINDOW-1:0], (clicks >= thr_clicks)};
		now_in = hits_upto(w - 1) >= hits_reg;

		if (enc_open && !now_in) begin
			// close: newest hit behind the current block
			pos = back_clamped(b, w);
			found = 1'b0;
			for (k = 1; k <= w && !found; k++) begin
				if (recent_hits[k]) begin
					pos = b - INDEX_BITS'(k);
					found = 1'b1;
				end
			end
			enc = '{open_first, pos, 1'b0};
			closed = 1'b1;
		end else if (!enc_open && now_in) begin
			// open: oldest hit in the window or the block that just left it
			pos = back_clamped(b, w);
			found = 1'b0;
			for (k = w; k >= 0 && !found; k--) begin
				if (recent_hits[k]) begin
					pos = b - INDEX_BITS'(k);
					found = 1'b1;
				end
			end
			open_first = pos;
		end
		enc_open = now_in;

		if (is_last) begin
			// drain the window oldest first until the sum drops below the threshold
			if (enc_open) begin
				found = 1'b0;
				for (d = 1; d <= w && !found; d++) begin
					if (hits_upto(w - 1 - d) < hits_reg) begin
						pos = back_clamped(b, w - d);
						for (k = 0; k <= w - d && !found; k++) begin
							if (recent_hits[k]) begin
								pos = b - INDEX_BITS'(k);
								found = 1'b1;
							end
						end
						found = 1'b1;
						enc = '{open_first, pos, 1'b1};
					end
				end
				if (!found)
					enc = '{open_first, b, 1'b1};
				closed = 1'b1;
			end
			clear_tracker();
		end else begin
			blk_idx = b + 1'b1;
		end
	endtask

	task automatic report_field(input string what, input logic [31:0] want,
		input logic [31:0] got);
		errors++;
		$display("MISMATCH %s: expected %0d, observed %0d at %0t", what, want, got, $time);
	endtask

	function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
		stim_row_t r;
		r = '0;
		r.kind = ROW_REG;
		r.reg_idx = idx;
		r.reg_val = v;
		return r;
	endfunction

	function automatic stim_row_t blk_row(logic [COUNT_BITS-1:0] c, logic l);
		stim_row_t r;
		r = '0;
		r.kind = ROW_BLOCK;
		r.clicks = c;
		r.is_last = l;
		return r;
	endfunction

	function automatic stim_row_t blk_row_exp(logic [COUNT_BITS-1:0] c, logic l,
		logic [INDEX_BITS-1:0] s, logic [INDEX_BITS-1:0] e, logic flag);
		stim_row_t r;
		r = blk_row(c, l);
		r.typed = 1'b1;
		r.want = '{s, e, flag};
		return r;
	endfunction

	// Offer one beat and hold it until accepted, then predict its result
	task automatic send_block(input logic [COUNT_BITS-1:0] clicks, input logic is_last,
		input logic typed, input encounter_t typed_enc);
		bit closed;
		encounter_t enc;
		blk_ch.valid       <= 1'b1;
		blk_ch.click_count <= clicks;
		blk_ch.last_block  <= is_last;
		do
			@(posedge clk);
		while (!blk_ch.ready);
		track_encounters(clicks, is_last, closed, enc);
		if (typed) begin
			closed = 1'b1;
			enc = typed_enc;
		end
		if (closed)
			due_encounters.push_back(enc);
	endtask

	// Random sender gap: mostly none or short, now and then long
	task automatic sender_gap();
		int gap;
		gap = 0;
		if (!tx_calm && $urandom_range(0, 9) >= 6)
			gap = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3) : $urandom_range(15, 50);
		if (gap > 0) begin
			blk_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop offering, wait for every due encounter, then let the back end finish
	task automatic wait_idle();
		blk_ch.valid <= 1'b0;
		while (due_encounters.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register; the caller lowers the write enable after the last one
	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		case (idx)
			REG_CLICKS: thr_clicks = v[CLICKS_W-1:0];
			REG_WINDOW: win_reg    = v[WINREG_W-1:0];
			REG_HITS:   hits_reg   = v[HITS_W-1:0];
			default: ;
		endcase
	endtask

	// Program a subset of the registers while the block is idle; upper data bits are noise
	task automatic program_regs(input logic [2:0] mask, input logic [CLICKS_W-1:0] c,
		input logic [WINREG_W-1:0] w, input logic [HITS_W-1:0] h);
		wait_idle();
		settings_count++;
		if (mask[0])
			put_reg(REG_CLICKS, c);
		if (mask[1])
			put_reg(REG_WINDOW, {9'($urandom), w});
		if (mask[2])
			put_reg(REG_HITS, {9'($urandom), h});
		cfg_we <= 1'b0;
	endtask

	function automatic logic [COUNT_BITS-1:0] draw_clicks(bit want_hit);
		if ($urandom_range(0, 9) == 0)
			return COUNT_BITS'($urandom);
		if (want_hit)
			return COUNT_BITS'($urandom_range(int'(thr_clicks), 65535));
		if (thr_clicks == 0)
			return COUNT_BITS'($urandom);
		return COUNT_BITS'($urandom_range(0, int'(thr_clicks) - 1));
	endfunction

	// Check each encounter beat against the oldest due one
	always @(posedge clk) begin
		if (arst_n && enc_ch.valid && enc_ch.ready) begin
			if (due_encounters.size() == 0) begin
				report_field("encounter with none due, enc_start", 32'(0),
					32'(enc_ch.enc_start));
			end else begin
				oldest_due = due_encounters.pop_front();
				if (enc_ch.enc_start !== oldest_due.first_blk)
					report_field("enc_start", 32'(oldest_due.first_blk),
						32'(enc_ch.enc_start));
				if (enc_ch.enc_end !== oldest_due.last_blk)
					report_field("enc_end", 32'(oldest_due.last_blk), 32'(enc_ch.enc_end));
				if (enc_ch.at_stream_end !== oldest_due.drained)
					report_field("at_stream_end", 32'(oldest_due.drained),
						32'(enc_ch.at_stream_end));
				seen_encounters++;
				if (oldest_due.drained)
					drained_encounters++;
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (blk_ch.valid && blk_ch.ready) || (enc_ch.valid && enc_ch.ready) || cfg_we) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", STALL_LIMIT);
				$display("sliding_window_encounter_detector_top verification failed");
				$finish;
			end
		end
	end

	// Receiver: random short and long stalls, calm stretches, and one requested long hold
	initial begin
		enc_ch.ready = 1'b0;
		rx_gap = 0;
		rx_span = 0;
		rx_calm = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				long_holds++;
				enc_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				enc_ch.ready <= 1'b1;
			end else begin
				if (rx_span == 0) begin
					rx_calm = ($urandom_range(0, 3) == 0);
					rx_span = $urandom_range(50, 300);
				end
				rx_span--;
				if (rx_gap > 0) begin
					rx_gap--;
					enc_ch.ready <= 1'b0;
				end else begin
					enc_ch.ready <= 1'b1;
					if (!rx_calm && $urandom_range(0, 9) < 3)
						rx_gap = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3)
							: $urandom_range(15, 60);
				end
			end
		end
	end

	// Stimulus
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		blk_ch.valid = 1'b0;
		blk_ch.click_count = '0;
		blk_ch.last_block = 1'b0;
		hold_request = 1'b0;
		tx_calm = 1'b0;
		cfg_open = 1'b0;
		thr_clicks = CLICKS_AT_RESET;
		win_reg = WINDOW_AT_RESET;
		hits_reg = HITS_AT_RESET;
		clear_tracker();

		// Reset settings: threshold hit, open and close by window slide, close on the last block
		directed_rows.push_back(blk_row(16'hFFFF, 1'b0));
		directed_rows.push_back(blk_row(16'd15, 1'b0));
		directed_rows.push_back(blk_row(16'd14, 1'b0));
		directed_rows.push_back(blk_row(16'hFFFF, 1'b0));
		directed_rows.push_back(blk_row(16'd20, 1'b0));
		directed_rows.push_back(blk_row(16'd100, 1'b0));
		repeat (4) directed_rows.push_back(blk_row(16'd0, 1'b0));
		directed_rows.push_back(blk_row_exp(16'd0, 1'b0, 24'd0, 24'd5, 1'b0));
		directed_rows.push_back(blk_row(16'd30, 1'b0));
		directed_rows.push_back(blk_row(16'd30, 1'b0));
		directed_rows.push_back(blk_row_exp(16'd0, 1'b1, 24'd3, 24'd12, 1'b0));
		// Encounter still open on the last block: closed by the drain
		repeat (5) directed_rows.push_back(blk_row(16'd50, 1'b0));
		directed_rows.push_back(blk_row_exp(16'd0, 1'b1, 24'd0, 24'd4, 1'b1));
		// Zero threshold, shortest window: start falls back to index 0, drain never closes
		directed_rows.push_back(reg_row(REG_HITS, 16'd0));
		directed_rows.push_back(reg_row(REG_WINDOW, 16'd1));
		directed_rows.push_back(blk_row(16'd0, 1'b0));
		directed_rows.push_back(blk_row_exp(16'hFFFF, 1'b1, 24'd0, 24'd1, 1'b1));
		// Window above the maximum acts as the maximum; zero click threshold
		directed_rows.push_back(reg_row(REG_WINDOW, 16'd127));
		directed_rows.push_back(reg_row(REG_HITS, 16'd2));
		directed_rows.push_back(reg_row(REG_CLICKS, 16'd0));
		directed_rows.push_back(blk_row(16'd0, 1'b0));
		directed_rows.push_back(blk_row_exp(16'd0, 1'b1, 24'd0, 24'd1, 1'b1));
		// Highest click threshold
		directed_rows.push_back(reg_row(REG_CLICKS, 16'hFFFF));
		directed_rows.push_back(reg_row(REG_WINDOW, 16'd1));
		directed_rows.push_back(reg_row(REG_HITS, 16'd1));
		directed_rows.push_back(blk_row(16'hFFFF, 1'b0));
		directed_rows.push_back(blk_row_exp(16'hFFFE, 1'b1, 24'd0, 24'd0, 1'b0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed rows; register rows wait for an idle block
		for (i = 0; i < directed_rows.size(); i++) begin
			row = directed_rows[i];
			if (row.kind == ROW_REG) begin
				if (!cfg_open) begin
					wait_idle();
					settings_count++;
					cfg_open = 1'b1;
				end
				put_reg(row.reg_idx, row.reg_val);
			end else begin
				if (cfg_open) begin
					cfg_we <= 1'b0;
					cfg_open = 1'b0;
				end
				send_block(row.clicks, row.is_last, row.typed, row.want);
				directed_blocks++;
				sender_gap();
			end
		end

		// Random phases of bursty hit streams, most ending with a last block
		phase = 0;
		while (random_blocks < RANDOM_BLOCKS) begin
			phase++;
			run_len = $urandom_range(4, 40);
			tx_calm = ($urandom_range(0, 3) == 0);
			if (phase == 3) begin
				// back-to-back closes against a long output hold
				program_regs(3'b111, 16'd1, 7'd1, 7'd1);
				tx_calm = 1'b1;
				run_len = 30;
				hold_request = 1'b1;
			end else if (phase == 1 || $urandom_range(0, 9) < 7) begin
				case ($urandom_range(0, 19))
					0:       new_window = 7'd0;
					1:       new_window = 7'($urandom_range(65, 127));
					2, 3:    new_window = 7'd64;
					default: new_window = 7'($urandom_range(1, 16));
				endcase
				case ($urandom_range(0, 19))
					0:       new_hits = 7'd0;
					1:       new_hits = 7'($urandom_range(65, 127));
					default: new_hits = 7'($urandom_range(1, (new_window == 0) ? 1
						: (new_window > 12) ? 12 : int'(new_window)));
				endcase
				case ($urandom_range(0, 19))
					0:       new_clicks = 16'd0;
					1:       new_clicks = 16'hFFFF;
					default: new_clicks = 16'($urandom_range(1, 65535));
				endcase
				write_mask = (phase == 1) ? 3'b111 : 3'($urandom_range(1, 7));
				program_regs(write_mask, new_clicks, new_window, new_hits);
			end

			burst = 1'b0;
			for (i = 0; i < run_len; i++) begin
				if ($urandom_range(0, 99) < 15)
					burst = !burst;
				if (i == run_len - 1)
					end_run = ($urandom_range(0, 3) != 0);
				else
					end_run = ($urandom_range(0, 49) == 0);
				if (phase == 3)
					send_block(i[0] ? 16'd0 : 16'hFFFF, end_run, 1'b0, '0);
				else
					send_block(draw_clicks(burst ? $urandom_range(0, 9) < 8
						: $urandom_range(0, 9) == 0), end_run, 1'b0, '0);
				random_blocks++;
				sender_gap();
			end

			// pause the sender until every due encounter has arrived
			if (phase % 7 == 0)
				wait_idle();
		end

		wait_idle();
		$display("Run covered %0d directed and %0d random blocks over %0d register settings.",
			directed_blocks, random_blocks, settings_count);
		$display("Checked %0d encounters, %0d closed by the drain, %0d long output hold(s).",
			seen_encounters, drained_encounters, long_holds);
		if (errors == 0)
			$display("sliding_window_encounter_detector_top verification clean");
		else
			$display("sliding_window_encounter_detector_top verification failed");
		$finish;
	end

endmodule
